// ===== sv/robb_pkg.sv =====
// Shared constants for the ray / oriented-box slab test.
// No dependencies; imported by ray_obb_slab_test.
package robb_pkg;

  // Default coordinate format (signed Q10.10)
  localparam int COORD_WIDTH_DEF = 20;
  localparam int FRAC_BITS_DEF   = 10;

  // Configuration register width and result distance width
  localparam int CFG_W  = 60;
  localparam int DIST_W = 19;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd5;

endpackage

// ===== sv/ray_obb_slab_test.sv =====
// Ray against oriented box slab test, fully pipelined datapath.
// From start to out_valid a ray passes stages 1 to 4, the restoring divider
// pipeline (one quotient bit per stage) and post stages 1 to 3.
// Throughput: one ray per cycle while busy is low; the receiver cannot stall the pipeline.
// After a box register write, busy is high while the axis norms are
// recomputed (one root bit per cycle). Reset clears config to 0.
// Depends on robb_pkg.
module ray_obb_slab_test
  import robb_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // ray input
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_ray_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_ray_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_ray_origin_z,
  input  logic signed [COORD_WIDTH-1:0] in_ray_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_ray_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_ray_dir_z,
  // result
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [DIST_W-1:0]             out_hit_distance,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int W     = COORD_WIDTH;
  localparam int PW    = W + 1;              // centre offset
  localparam int EW    = 2 * W + 3;          // axis . offset
  localparam int GW    = 2 * W + 2;          // axis . direction
  localparam int SW    = 2 * W + 1;          // scaled extent
  localparam int NW    = 2 * W + 5;          // slab numerator
  localparam int DENW  = 2 * W + 1;          // divisor magnitude
  localparam int DW    = NW - 1 + FRAC_BITS; // dividend / quotient bits
  localparam int TW    = DW + 1;             // signed distance
  localparam int CNTW  = $clog2(W + 1);
  localparam int LAT   = DW + 8;
  localparam int DMAX  = (W - 1 < DIST_W) ? (1 << (W - 1)) - 1 : (1 << DIST_W) - 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_RT   = 2'd2;
  localparam logic [1:0] ST_SC   = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [CFG_W-1:0] cfg_reg_r [5];
  logic             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready && (cfg_index < REG_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) cfg_reg_r[i] <= '0;
    end else if (cfg_wr) begin
      cfg_reg_r[cfg_index] <= cfg_data;
    end
  end

  // Unpack elements; bits above the register read as zero
  logic signed [W-1:0] ax  [3][3];
  logic signed [W-1:0] cen [3];
  logic signed [W-1:0] siz [3];
  logic [63:0]         wide [5];

  always_comb begin
    for (int r = 0; r < 5; r++) wide[r] = {{(64 - CFG_W){1'b0}}, cfg_reg_r[r]};
    for (int j = 0; j < 3; j++) begin
      ax[0][j] = signed'(wide[REG_AXIS_X][j*W +: W]);
      ax[1][j] = signed'(wide[REG_AXIS_Y][j*W +: W]);
      ax[2][j] = signed'(wide[REG_AXIS_Z][j*W +: W]);
      cen[j]   = signed'(wide[REG_CENTER][j*W +: W]);
      siz[j]   = signed'(wide[REG_SIZE][j*W +: W]);
    end
  end

  // ---------------------------------------------------------------------------
  // Norm sequencer: per axis, sum of squares, floor square root, scale extent
  logic [1:0]           state_r, state_nxt;
  logic [1:0]           axis_r, axis_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic [2*W-1:0]       nn_r, nn_nxt;
  logic [2*W-1:0]       x_r, x_nxt;
  logic [W+1:0]         rem_r, rem_nxt;
  logic [W-1:0]         root_r, root_nxt;
  logic signed [SW-1:0] scl_r [3];
  logic signed [2*W-1:0] sq;
  logic [W+1:0]         rem_t, trial_t;
  logic signed [SW-1:0] scl_prod;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    nn_nxt    = nn_r;
    x_nxt     = x_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    sq        = ax[axis_r][cnt_r[1:0]] * ax[axis_r][cnt_r[1:0]];
    rem_t     = {rem_r[W-1:0], x_r[2*W-1 -: 2]};
    trial_t   = {root_r, 2'b01};
    scl_prod  = SW'(siz[axis_r]) * SW'(signed'({1'b0, root_r}));
    case (state_r)
      ST_IDLE: ;
      ST_SQ: begin
        nn_nxt = nn_r + unsigned'(sq);
        if (cnt_r == CNTW'(2)) begin
          state_nxt = ST_RT;
          cnt_nxt   = '0;
          x_nxt     = nn_nxt;
          rem_nxt   = '0;
          root_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_RT: begin
        // one root bit per cycle
        x_nxt = {x_r[2*W-3:0], 2'b00};
        if (rem_t >= trial_t) begin
          rem_nxt  = rem_t - trial_t;
          root_nxt = {root_r[W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_t;
          root_nxt = {root_r[W-2:0], 1'b0};
        end
        if (cnt_r == CNTW'(W - 1)) state_nxt = ST_SC;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_SC: begin
        if (axis_r == 2'd2) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SQ;
          axis_nxt  = axis_r + 1'b1;
          cnt_nxt   = '0;
          nn_nxt    = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // any register transfer restarts the whole pass
    if (cfg_wr) begin
      state_nxt = ST_SQ;
      axis_nxt  = '0;
      cnt_nxt   = '0;
      nn_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      cnt_r   <= '0;
      for (int k = 0; k < 3; k++) scl_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == ST_SC && !cfg_wr) scl_r[axis_r] <= scl_prod;
    end
  end

  always_ff @(posedge clk) begin
    nn_r   <= nn_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  // ---------------------------------------------------------------------------
  // Stage 1: centre offset and direction
  logic                 acc;
  logic                 v1_r, v2_r, v3_r, v4_r;
  logic signed [PW-1:0] p1_r [3];
  logic signed [W-1:0]  d1_r [3];
  logic signed [W-1:0]  org [3];
  logic signed [W-1:0]  dir [3];

  assign acc = start && !busy;
  assign org = '{in_ray_origin_x, in_ray_origin_y, in_ray_origin_z};
  assign dir = '{in_ray_dir_x, in_ray_dir_y, in_ray_dir_z};

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      p1_r[j] <= PW'(cen[j]) - PW'(org[j]);
      d1_r[j] <= dir[j];
    end
  end

  // Stage 2: products against each axis column
  logic signed [2*W:0]   pe2_r [3][3];
  logic signed [2*W-1:0] pg2_r [3][3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        pe2_r[k][j] <= ax[k][j] * p1_r[j];
        pg2_r[k][j] <= ax[k][j] * d1_r[j];
      end
    end
  end

  // Stage 3: dot products
  logic signed [EW-1:0] e3_r [3];
  logic signed [GW-1:0] g3_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e3_r[k] <= EW'(pe2_r[k][0]) + EW'(pe2_r[k][1]) + EW'(pe2_r[k][2]);
      g3_r[k] <= GW'(pg2_r[k][0]) + GW'(pg2_r[k][1]) + GW'(pg2_r[k][2]);
    end
  end

  // Stage 4: slab numerators, divisor magnitude, skip flags
  logic signed [NW-1:0] n4_r [6];
  logic [DENW-1:0]      den4_r [3];
  logic                 gs4_r [3];
  logic                 skip4_r [3];
  logic [GW-1:0]        gmag [3];

  always_comb begin
    for (int k = 0; k < 3; k++) gmag[k] = g3_r[k][GW-1] ? GW'(-g3_r[k]) : GW'(g3_r[k]);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      n4_r[2*k]   <= NW'(e3_r[k]) + NW'(e3_r[k]) + NW'(scl_r[k]);
      n4_r[2*k+1] <= NW'(e3_r[k]) + NW'(e3_r[k]) - NW'(scl_r[k]);
      den4_r[k]   <= {gmag[k][2*W-1:0], 1'b0};
      gs4_r[k]    <= g3_r[k][GW-1];
      skip4_r[k]  <= (g3_r[k] == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider pipeline: six lanes, one quotient bit per stage
  logic [DENW-1:0] dv_rem  [0:DW][6];
  logic [DW-1:0]   dv_dq   [0:DW][6];
  logic            dv_neg  [0:DW][6];
  logic [DENW-1:0] dv_den  [0:DW][3];
  logic            dv_skip [0:DW][3];
  logic            dv_v_r  [0:DW];
  logic [NW-1:0]   nmag [6];

  always_comb begin
    for (int l = 0; l < 6; l++) nmag[l] = n4_r[l][NW-1] ? NW'(-n4_r[l]) : NW'(n4_r[l]);
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 6; l++) begin
      dv_rem[0][l] <= '0;
      dv_dq[0][l]  <= {nmag[l][NW-2:0], {FRAC_BITS{1'b0}}};
      dv_neg[0][l] <= n4_r[l][NW-1] ^ gs4_r[l/2];
    end
    for (int k = 0; k < 3; k++) begin
      dv_den[0][k]  <= den4_r[k];
      dv_skip[0][k] <= skip4_r[k];
    end
  end

  for (genvar i = 0; i < DW; i++) begin : g_div
    logic [DENW:0] trial [6];
    logic [DENW:0] diff  [6];
    logic          ge    [6];

    always_comb begin
      for (int l = 0; l < 6; l++) begin
        trial[l] = {dv_rem[i][l], dv_dq[i][l][DW-1]};
        diff[l]  = trial[l] - {1'b0, dv_den[i][l/2]};
        ge[l]    = (trial[l] >= {1'b0, dv_den[i][l/2]});
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 6; l++) begin
        dv_rem[i+1][l] <= ge[l] ? diff[l][DENW-1:0] : trial[l][DENW-1:0];
        dv_dq[i+1][l]  <= {dv_dq[i][l][DW-2:0], ge[l]};
        dv_neg[i+1][l] <= dv_neg[i][l];
      end
      for (int k = 0; k < 3; k++) begin
        dv_den[i+1][k]  <= dv_den[i][k];
        dv_skip[i+1][k] <= dv_skip[i][k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[i+1] <= 1'b0;
      else dv_v_r[i+1] <= dv_v_r[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Post 1: signed distances, ordered per axis
  logic signed [TW-1:0] t [6];
  logic signed [TW-1:0] lo5_r [3];
  logic signed [TW-1:0] hi5_r [3];
  logic                 skip5_r [3];
  logic                 v5_r, v6_r;

  always_comb begin
    for (int l = 0; l < 6; l++) begin
      t[l] = dv_neg[DW][l] ? -signed'({1'b0, dv_dq[DW][l]}) : signed'({1'b0, dv_dq[DW][l]});
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      lo5_r[k]   <= (t[2*k] > t[2*k+1]) ? t[2*k+1] : t[2*k];
      hi5_r[k]   <= (t[2*k] > t[2*k+1]) ? t[2*k] : t[2*k+1];
      skip5_r[k] <= dv_skip[DW][k];
    end
  end

  // Post 2: entry is the latest near plane, exit the earliest far plane
  logic signed [TW-1:0] tmin, tmax;
  logic                 bnd;
  logic signed [TW-1:0] tmin6_r, tmax6_r;
  logic                 bnd6_r;

  always_comb begin
    tmin = '0;
    tmax = '0;
    bnd  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!skip5_r[k]) begin
        if (!bnd || lo5_r[k] > tmin) tmin = lo5_r[k];
        if (!bnd || hi5_r[k] < tmax) tmax = hi5_r[k];
        bnd = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tmin6_r <= tmin;
    tmax6_r <= tmax;
    bnd6_r  <= bnd;
  end

  // Post 3: hit decision and saturation into the output register
  logic              hit_c;
  logic              out_valid_r;
  logic              out_hit_r;
  logic [DIST_W-1:0] out_dist_r;

  assign hit_c = bnd6_r && !(tmin6_r > tmax6_r) && (tmin6_r > TW'(0));

  always_ff @(posedge clk) begin
    out_hit_r <= hit_c;
    if (!hit_c) out_dist_r <= '0;
    else if (tmin6_r > TW'(DMAX)) out_dist_r <= DIST_W'(DMAX);
    else out_dist_r <= tmin6_r[DIST_W-1:0];
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      dv_v_r[0]   <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= acc;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      dv_v_r[0]   <= v4_r;
      v5_r        <= dv_v_r[DW];
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_distance = out_dist_r;

  // ---------------------------------------------------------------------------
  // Assertions
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("accepted ray produced no result at the expected latency");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_distance == '0)
    else $error("miss with non-zero distance");

  a_hit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_hit_distance != '0)
    else $error("hit with zero distance");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy)
    else $error("box register transfer did not start norm recompute");

endmodule
